// ===== hw/rtl/tmeu_pkg.sv =====
package tmeu_pkg;

    // Configuration port
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int INSN_LIMIT_W   = 32;
    localparam int CELL_LIMIT_W   = 13;

    localparam logic [INSN_LIMIT_W-1:0] INSN_LIMIT_RST = 32'hFFFF_FFFF;
    localparam logic [CELL_LIMIT_W-1:0] CELL_LIMIT_RST = 13'd4096;

    // Payload widths
    localparam int OP_W     = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INSN_LIMIT = 1'b0,
        CFG_CELL_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [OP_W-1:0] {
        OP_RIGHT  = 3'd0,
        OP_LEFT   = 3'd1,
        OP_INC    = 3'd2,
        OP_DEC    = 3'd3,
        OP_OPEN   = 3'd4,
        OP_CLOSE  = 3'd5,
        OP_OUTPUT = 3'd6,
        OP_INPUT  = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN   = 3'd0,
        ST_ILIM  = 3'd1,
        ST_CLIM  = 3'd2,
        ST_UNDER = 3'd3,
        ST_EOF   = 3'd4
    } status_t;

endpackage

// ===== hw/rtl/tmeu_ram.sv =====
module tmeu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/tape_machine_execute_unit.sv =====
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------------
// request | req_valid/req_ready  | req_type, in_byte, in_end
// result  | res_valid/res_ready  | out_byte, out_valid, jump_taken, status
// config  | cfg_wen              | cfg_index, cfg_wdata
//
// One instruction per cycle sustained while results are taken; a result is valid
// once its request beat has passed the execute stage and the result register: the
// tape read issues at the request edge, and the cell update, write-back and result
// load happen as the execute stage advances. A one-entry forward register covers
// the write that lands in the same cycle as the following read. Reset clears
// pointer, count and status at once and writes cell 0 to zero in the first cycle
// after reset; other cells are cleared as the pointer first reaches them. A stalled
// result stops the execute stage, which then holds req_ready low.
module tape_machine_execute_unit #(
    parameter int TAPE_DEPTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic [tmeu_pkg::OP_W-1:0]           req_type,
    input  logic [tmeu_pkg::BYTE_W-1:0]         in_byte,
    input  logic                                in_end,

    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [tmeu_pkg::BYTE_W-1:0]         out_byte,
    output logic                                out_valid,
    output logic                                jump_taken,
    output logic [tmeu_pkg::STATUS_W-1:0]       status,

    input  logic                                cfg_wen,
    input  logic [tmeu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tmeu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import tmeu_pkg::*;

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam int CW = (AW + 1 > CELL_LIMIT_W) ? AW + 1 : CELL_LIMIT_W;

    // Execute-stage contents
    typedef struct packed {
        op_t             op;
        logic            exec;
        logic            clr;
        logic [BYTE_W-1:0] in_byte;
        logic [AW-1:0]   raddr;
        logic [AW-1:0]   waddr;
        status_t         status;
    } exe_t;

    // Configuration registers
    logic [INSN_LIMIT_W-1:0] ilim_reg;
    logic [CELL_LIMIT_W-1:0] clim_reg;

    // Architectural control state
    logic [AW-1:0]           dp_reg, dp_next;
    logic [AW-1:0]           hi_reg, hi_next;
    logic [INSN_LIMIT_W-1:0] cnt_reg, cnt_next;
    status_t                 halt_reg, halt_next;

    // Execute stage
    logic                    b_valid_reg;
    exe_t                    b_reg;
    exe_t                    b_next;
    logic                    b_adv;
    logic                    accept;

    // Forwarding of the latest tape write
    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic [BYTE_W-1:0]       fwd_data_reg;

    // Cell 0 clear right after reset
    logic                    clr0_reg;

    // Result register
    logic                    res_valid_reg;
    logic [BYTE_W-1:0]       out_byte_reg;
    logic                    out_valid_reg;
    logic                    jump_reg;
    status_t                 status_reg;

    // Tape port signals
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [BYTE_W-1:0]       mem_wdata;
    logic [BYTE_W-1:0]       mem_rdata;

    // Execute-stage combinational results
    logic [BYTE_W-1:0]       cell_val;
    logic                    wr_cell;
    logic [BYTE_W-1:0]       cell_wdata;
    logic [BYTE_W-1:0]       obyte;
    logic                    ovalid;
    logic                    jump;

    // Decode-stage helpers
    logic [INSN_LIMIT_W-1:0] cnt_inc;
    logic [AW:0]             nh;

    assign b_adv     = b_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !b_valid_reg || b_adv;
    assign accept    = req_valid && req_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ilim_reg <= INSN_LIMIT_RST;
            clim_reg <= CELL_LIMIT_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_INSN_LIMIT: ilim_reg <= cfg_wdata[INSN_LIMIT_W-1:0];
                CFG_CELL_LIMIT: clim_reg <= cfg_wdata[CELL_LIMIT_W-1:0];
                default:        ilim_reg <= ilim_reg;
            endcase
        end
    end

    // Count, pointer and halt decisions for the accepted beat
    always_comb
    begin
        cnt_inc   = cnt_reg + INSN_LIMIT_W'(1);
        nh        = (AW + 1)'(hi_reg) + (AW + 1)'(1);
        dp_next   = dp_reg;
        hi_next   = hi_reg;
        cnt_next  = cnt_reg;
        halt_next = halt_reg;
        b_next.op      = op_t'(req_type);
        b_next.exec    = 1'b0;
        b_next.clr     = 1'b0;
        b_next.in_byte = in_byte;
        b_next.raddr   = dp_reg;
        b_next.waddr   = dp_reg;
        if (accept && halt_reg == ST_RUN)
        begin
            cnt_next = cnt_inc;
            if (cnt_inc == ilim_reg)
            begin
                halt_next = ST_ILIM;
            end
            else
            begin
                case (op_t'(req_type))
                    OP_RIGHT:
                    begin
                        if (dp_reg >= hi_reg)
                        begin
                            if (CW'(nh) == CW'(clim_reg) || nh >= (AW + 1)'(TAPE_DEPTH))
                            begin
                                halt_next = ST_CLIM;
                            end
                            else
                            begin
                                hi_next      = nh[AW-1:0];
                                dp_next      = nh[AW-1:0];
                                b_next.clr   = 1'b1;
                                b_next.waddr = nh[AW-1:0];
                            end
                        end
                        else
                        begin
                            dp_next = dp_reg + AW'(1);
                        end
                    end
                    OP_LEFT:
                    begin
                        if (dp_reg == '0)
                        begin
                            halt_next = ST_UNDER;
                        end
                        else
                        begin
                            dp_next = dp_reg - AW'(1);
                        end
                    end
                    OP_INPUT:
                    begin
                        if (in_end)
                        begin
                            halt_next = ST_EOF;
                        end
                        else
                        begin
                            b_next.exec = 1'b1;
                        end
                    end
                    default:
                    begin
                        b_next.exec = 1'b1;
                    end
                endcase
            end
        end
        b_next.status = halt_next;
    end

    // Control state and execute-stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg      <= '0;
            hi_reg      <= '0;
            cnt_reg     <= '0;
            halt_reg    <= ST_RUN;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            dp_reg   <= dp_next;
            hi_reg   <= hi_next;
            cnt_reg  <= cnt_next;
            halt_reg <= halt_next;
            if (accept)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_reg <= b_next;
        end
    end

    // Hold the cell 0 clear for the first cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr0_reg <= 1'b1;
        end
        else
        begin
            clr0_reg <= 1'b0;
        end
    end

    // Tape memory
    tmeu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (dp_reg),
        .rdata (mem_rdata)
    );

    // Cell update: pick forwarded data, then modify
    always_comb
    begin
        cell_val   = (fwd_valid_reg && fwd_addr_reg == b_reg.raddr) ? fwd_data_reg
                                                                     : mem_rdata;
        wr_cell    = 1'b0;
        cell_wdata = cell_val;
        obyte      = '0;
        ovalid     = 1'b0;
        jump       = 1'b0;
        case (b_reg.op)
            OP_INC:
            begin
                wr_cell    = b_reg.exec;
                cell_wdata = cell_val + BYTE_W'(1);
            end
            OP_DEC:
            begin
                wr_cell    = b_reg.exec;
                cell_wdata = cell_val - BYTE_W'(1);
            end
            OP_OPEN:
            begin
                jump = b_reg.exec && (cell_val == '0);
            end
            OP_CLOSE:
            begin
                jump = b_reg.exec && (cell_val != '0);
            end
            OP_OUTPUT:
            begin
                obyte  = b_reg.exec ? cell_val : '0;
                ovalid = b_reg.exec;
            end
            OP_INPUT:
            begin
                wr_cell    = b_reg.exec;
                cell_wdata = b_reg.in_byte;
            end
            default:
            begin
                wr_cell = 1'b0;
            end
        endcase
    end

    // Write port: cell 0 clear after reset, else execute-stage write
    assign mem_we    = clr0_reg || (b_adv && (wr_cell || b_reg.clr));
    assign mem_waddr = clr0_reg ? '0 : b_reg.waddr;
    assign mem_wdata = (clr0_reg || b_reg.clr) ? '0 : cell_wdata;

    // Track the latest write for the next read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (mem_we)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fwd_addr_reg <= mem_waddr;
            fwd_data_reg <= mem_wdata;
        end
    end

    // Result register: load on advance, drop on take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            out_byte_reg  <= obyte;
            out_valid_reg <= ovalid;
            jump_reg      <= jump;
            status_reg    <= b_reg.status;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_valid  = out_valid_reg;
    assign jump_taken = jump_reg;
    assign status     = status_reg;

    // Pointer never passes the highest cell reached
    a_dp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dp_reg <= hi_reg)
        else $error("data pointer above highest cell");

    // Halt status is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg != ST_RUN |=> halt_reg == $past(halt_reg))
        else $error("halt status left a halted state");

    // Tape writes only from an advancing execute stage, apart from the cell 0 clear
    a_write_adv: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && !clr0_reg |-> b_adv)
        else $error("tape write without execute advance");

    // Accepted beat occupies the execute stage next cycle
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("accepted beat lost before execute");

    // Output characters only while running
    a_out_running: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> status == ST_RUN)
        else $error("output character with halted status");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tmeu_pkg::*;

    localparam int TAPE_CELLS = 4096;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_ready;
    logic [OP_W-1:0]        req_type;
    logic [BYTE_W-1:0]      in_byte;
    logic                   in_end;
    logic                   res_valid;
    logic                   res_ready;
    logic [BYTE_W-1:0]      out_byte;
    logic                   out_valid;
    logic                   jump_taken;
    logic [STATUS_W-1:0]    status;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // One predicted result beat, stamped with the edge its instruction was taken
    typedef struct {
        logic [7:0]      cell_out;
        logic            cell_out_valid;
        logic            jump;
        status_t         halt_st;
        longint unsigned noted_at;
    } tape_result_t;

    // Shadow of the tape machine: tape, pointer, count, halt state and limits
    class tape_tracker;
        logic [7:0]    cells [TAPE_CELLS];
        int unsigned   dp;
        int unsigned   top;
        logic [31:0]   executed;
        logic [31:0]   insn_limit;
        logic [12:0]   cell_limit;
        status_t       halt;
        tape_result_t  due_results [$];
        int unsigned   errors;
        int unsigned   matched;

        function new();
            foreach (cells[i])
                cells[i] = 8'h00;
            dp         = 0;
            top        = 0;
            executed   = '0;
            insn_limit = INSN_LIMIT_RST;
            cell_limit = CELL_LIMIT_RST;
            halt       = ST_RUN;
            errors     = 0;
            matched    = 0;
        endfunction

        function bit is_halted();
            return halt != ST_RUN;
        endfunction

        // Tell which halt an instruction would cause from the current state
        function status_t halt_cause(op_t op, logic eoi);
            if (halt != ST_RUN)
                return ST_RUN;
            if (executed + 32'd1 == insn_limit)
                return ST_ILIM;
            case (op)
                OP_RIGHT:
                    if (dp >= top && (top + 1 == cell_limit || top + 1 >= TAPE_CELLS))
                        return ST_CLIM;
                OP_LEFT:
                    if (dp == 0)
                        return ST_UNDER;
                OP_INPUT:
                    if (eoi)
                        return ST_EOF;
                default: ;
            endcase
            return ST_RUN;
        endfunction

        // Execute one instruction beat and queue the result it produces
        function void take_insn(op_t op, logic [7:0] ib, logic eoi, longint unsigned stamp);
            tape_result_t r;
            logic [7:0]   c;
            r.cell_out       = 8'h00;
            r.cell_out_valid = 1'b0;
            r.jump           = 1'b0;
            r.noted_at       = stamp;
            if (halt == ST_RUN) begin
                executed = executed + 32'd1;
                if (executed == insn_limit) begin
                    halt = ST_ILIM;
                end else begin
                    c = cells[dp];
                    case (op)
                        OP_RIGHT: begin
                            if (dp >= top) begin
                                if (top + 1 == cell_limit || top + 1 >= TAPE_CELLS) begin
                                    halt = ST_CLIM;
                                end else begin
                                    top        = top + 1;
                                    dp         = top;
                                    cells[top] = 8'h00;
                                end
                            end else begin
                                dp = dp + 1;
                            end
                        end
                        OP_LEFT: begin
                            if (dp == 0)
                                halt = ST_UNDER;
                            else
                                dp = dp - 1;
                        end
                        OP_INC:   cells[dp] = c + 8'd1;
                        OP_DEC:   cells[dp] = c - 8'd1;
                        OP_OPEN:  r.jump = (c == 8'h00);
                        OP_CLOSE: r.jump = (c != 8'h00);
                        OP_OUTPUT: begin
                            r.cell_out       = c;
                            r.cell_out_valid = 1'b1;
                        end
                        default: begin
                            if (eoi)
                                halt = ST_EOF;
                            else
                                cells[dp] = ib;
                        end
                    endcase
                end
            end
            r.halt_st = halt;
            due_results.push_back(r);
        endfunction

        // Compare a result beat with the oldest instruction taken at an earlier edge
        function void match_result(logic [7:0] ob, logic ov, logic jt, logic [2:0] st,
                                   longint unsigned stamp);
            tape_result_t want;
            if (due_results.size() == 0 || due_results[0].noted_at == stamp) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result beat with nothing pending: byte %02h valid %0b jump %0b status %0d",
                             $time, ob, ov, jt, st);
                return;
            end
            want = due_results.pop_front();
            if (ob !== want.cell_out || ov !== want.cell_out_valid || jt !== want.jump
                    || st !== want.halt_st) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result %0d expected byte %02h valid %0b jump %0b status %0d, got byte %02h valid %0b jump %0b status %0d",
                             $time, matched, want.cell_out, want.cell_out_valid, want.jump,
                             want.halt_st, ob, ov, jt, st);
            end
            matched++;
        endfunction
    endclass

    tape_tracker tracker;

    bit      idle_on;
    bit      stalls_on;
    op_t     favored;
    int      favor_pct;
    status_t final_halt;

    tape_machine_execute_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .in_byte    (in_byte),
        .in_end     (in_end),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .jump_taken (jump_taken),
        .status     (status),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // End the run if the block hangs
    initial
    begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Check every result beat
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            tracker.match_result(out_byte, out_valid, jump_taken, status, $time);
    end

    // Drop ready in random bursts while stalls are on
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        res_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (stalls_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 4);
            res_ready <= (stall_left == 0) && rst_n;
        end
    end

    // Present one instruction beat and hold it until taken
    task automatic send_insn(op_t op, logic [7:0] ib, logic eoi);
        req_valid <= 1'b1;
        req_type  <= op;
        in_byte   <= ib;
        in_end    <= eoi;
        do
            @(posedge clk);
        while (!req_ready);
        tracker.take_insn(op, ib, eoi, $time);
    endtask

    // Hold off requests until every result is back, then let the pipe settle
    task automatic drain_results();
        req_valid <= 1'b0;
        while (tracker.due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both limit registers on back-to-back edges
    task automatic set_limits(logic [31:0] ilim, logic [12:0] clim);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_INSN_LIMIT;
        cfg_wdata <= ilim;
        @(posedge clk);
        cfg_index <= CFG_CELL_LIMIT;
        cfg_wdata <= 32'(clim);
        @(posedge clk);
        cfg_wen <= 1'b0;
        tracker.insn_limit = ilim;
        tracker.cell_limit = clim;
    endtask

    function automatic op_t pick_op();
        int r;
        if ($urandom_range(0, 99) < favor_pct)
            return favored;
        r = $urandom_range(0, 99);
        if (r < 14)
            return OP_RIGHT;
        if (r < 28)
            return OP_LEFT;
        if (r < 48)
            return OP_INC;
        if (r < 62)
            return OP_DEC;
        if (r < 70)
            return OP_OPEN;
        if (r < 78)
            return OP_CLOSE;
        if (r < 90)
            return OP_OUTPUT;
        return OP_INPUT;
    endfunction

    // Random instruction; steer from any halt but the allowed one or the insn limit
    task automatic send_random(bit halt_ok);
        op_t        op;
        logic [7:0] ib;
        logic       eoi;
        status_t    cause;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        op    = pick_op();
        ib    = 8'($urandom);
        eoi   = 1'($urandom_range(0, 1));
        cause = tracker.halt_cause(op, eoi);
        if (cause != ST_RUN && !(halt_ok && cause == final_halt)) begin
            if (cause == ST_EOF)
                eoi = 1'b0;
            else if (cause != ST_ILIM)
                op = OP_INC;
        end
        send_insn(op, ib, eoi);
    endtask

    initial
    begin : stimulus
        tracker    = new();
        idle_on    = 1'b0;
        stalls_on  = 1'b0;
        favored    = OP_RIGHT;
        favor_pct  = 0;
        final_halt = ST_RUN;
        req_valid <= 1'b0;
        req_type  <= OP_RIGHT;
        in_byte   <= 8'h00;
        in_end    <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_index <= CFG_INSN_LIMIT;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_limits(INSN_LIMIT_RST, CELL_LIMIT_RST);

        // Directed: write cell 0 first, then wrap, brackets, moves and output
        send_insn(OP_INPUT,  8'h00, 1'b0);
        send_insn(OP_OPEN,   8'hFF, 1'b0);
        send_insn(OP_CLOSE,  8'h00, 1'b1);
        send_insn(OP_DEC,    8'h00, 1'b0);
        send_insn(OP_OUTPUT, 8'h00, 1'b0);
        send_insn(OP_OPEN,   8'h00, 1'b0);
        send_insn(OP_CLOSE,  8'h00, 1'b0);
        send_insn(OP_INC,    8'hFF, 1'b1);
        send_insn(OP_OUTPUT, 8'h00, 1'b0);
        send_insn(OP_INPUT,  8'hFF, 1'b0);
        send_insn(OP_OUTPUT, 8'h00, 1'b0);
        send_insn(OP_INPUT,  8'hA5, 1'b0);
        send_insn(OP_RIGHT,  8'hFF, 1'b1);
        send_insn(OP_OUTPUT, 8'h00, 1'b1);
        send_insn(OP_INC,    8'h00, 1'b0);
        send_insn(OP_LEFT,   8'h00, 1'b0);
        send_insn(OP_OUTPUT, 8'h00, 1'b0);
        send_insn(OP_RIGHT,  8'h00, 1'b0);
        send_insn(OP_OUTPUT, 8'h00, 1'b0);
        send_insn(OP_RIGHT,  8'h00, 1'b0);
        send_insn(OP_RIGHT,  8'h00, 1'b0);
        send_insn(OP_LEFT,   8'h00, 1'b0);
        send_insn(OP_LEFT,   8'h00, 1'b0);
        send_insn(OP_LEFT,   8'h00, 1'b0);
        send_insn(OP_INPUT,  8'h5A, 1'b0);

        // Random phases, each with its own idling; all but phase 0 set their own limits
        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            favor_pct = 0;
            case (phase)
                0: begin
                    idle_on   = 1'b1;
                    stalls_on = 1'b1;
                end
                1: begin
                    set_limits(32'd1, 13'd1);
                    idle_on   = 1'b1;
                    stalls_on = 1'b0;
                end
                2: begin
                    set_limits(tracker.executed + 32'd1_000_000 + 32'($urandom_range(0, 1 << 20)),
                               13'($urandom_range(1, 4096)));
                    idle_on   = 1'b0;
                    stalls_on = 1'b1;
                    favored   = OP_RIGHT;
                    favor_pct = 20;
                end
                3: begin
                    set_limits(tracker.executed + 32'd5000 + 32'($urandom_range(0, 1 << 20)),
                               13'(tracker.top + $urandom_range(1, 4)));
                    idle_on   = 1'b1;
                    stalls_on = 1'b1;
                end
                default: begin
                    set_limits(INSN_LIMIT_RST, CELL_LIMIT_RST);
                    idle_on   = 1'b0;
                    stalls_on = 1'b0;
                end
            endcase
            for (int k = 0; k < 280; k++) begin
                if ($urandom_range(0, 149) == 0)
                    drain_results();
                send_random(1'b0);
            end
        end

        // Last part: drive the machine into one halt, then keep feeding it
        drain_results();
        final_halt = status_t'($urandom_range(1, 4));
        case (final_halt)
            ST_ILIM: begin
                set_limits(tracker.executed + 32'($urandom_range(3, 30)), CELL_LIMIT_RST);
                favor_pct = 0;
            end
            ST_CLIM: begin
                set_limits(INSN_LIMIT_RST, 13'(tracker.top + $urandom_range(1, 3)));
                favored   = OP_RIGHT;
                favor_pct = 60;
            end
            ST_UNDER: begin
                favored   = OP_LEFT;
                favor_pct = 60;
            end
            default: begin
                favored   = OP_INPUT;
                favor_pct = 30;
            end
        endcase
        while (!tracker.is_halted())
            send_random(1'b1);
        favor_pct = 0;
        repeat (20) send_random(1'b1);

        drain_results();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.due_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
